// ===== rtl/core/plid_pkg.sv =====
// Shared types and constants for the positional insert/delete list.
`timescale 1ns / 1ps

package plid_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_DELETE   = 3'd1,
    CMD_RETRIEVE = 3'd2,
    CMD_REPLACE  = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT
  } cell_op_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic [1:0]        status;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
    logic              is_full;
  } out_t;

endpackage

// ===== rtl/core/plid_cell.sv =====
// One list cell: holds one entry and takes a word from a neighbor or the command.
`timescale 1ns / 1ps

module plid_cell (
  input  logic                         clk,
  input  plid_pkg::cell_op_t           op,
  input  logic [plid_pkg::WORD_W-1:0]  load_word,
  input  logic [plid_pkg::WORD_W-1:0]  left_word,
  input  logic [plid_pkg::WORD_W-1:0]  right_word,
  output logic [plid_pkg::WORD_W-1:0]  word
);

  logic [plid_pkg::WORD_W-1:0] word_next;

  always_comb begin
    unique case (op)
      plid_pkg::CELL_LOAD:       word_next = load_word;
      plid_pkg::CELL_TAKE_LEFT:  word_next = left_word;
      plid_pkg::CELL_TAKE_RIGHT: word_next = right_word;
      default:                   word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== rtl/core/positional_insert_delete_list.sv =====
// Top level of the positional insert/delete list: cell row, count and result register.
`timescale 1ns / 1ps

// Ordered list of up to DEPTH 32-bit entries held in a row of cells, position 0 first.
// Every command (insert, delete, retrieve, replace, clear) is applied at once, as cells
// shift from their neighbor in parallel, so a new command word is taken each cycle that
// cmd_ready is high and its result word appears in the output register on the next cycle.
// The input is ready whenever the output register is empty or being drained.
// Errors (bad position, full, empty) leave the list unchanged; commands 5 to 7 are
// ignored with status ok. After reset the list is empty; no clearing pass is needed.

module positional_insert_delete_list #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  plid_pkg::in_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output plid_pkg::out_t rsp
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = (CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W;

  logic                        accept;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;
  logic [CMPW-1:0]             pos_ext;
  logic [CMPW-1:0]             count_ext;
  logic [AW-1:0]               rd_idx;
  logic                        do_insert;
  logic                        do_delete;
  logic                        do_replace;
  logic [1:0]                  status_next;
  logic [plid_pkg::WORD_W-1:0] read_next;
  plid_pkg::cell_op_t          cell_op [DEPTH];
  logic [plid_pkg::WORD_W-1:0] cell_word [DEPTH];

  assign accept    = cmd_valid && cmd_ready;
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign pos_ext   = CMPW'(cmd.position);
  assign count_ext = CMPW'(count);
  assign rd_idx    = pos_ext[AW-1:0];

  always_comb begin
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    do_replace  = 1'b0;
    status_next = plid_pkg::ST_OK;
    read_next   = '0;
    count_next  = count;
    unique case (cmd.cmd)
      plid_pkg::CMD_INSERT: begin
        if (pos_ext > count_ext) begin
          status_next = plid_pkg::ST_RANGE;
        end else if (count == CW'(DEPTH)) begin
          status_next = plid_pkg::ST_FULL;
        end else begin
          do_insert  = 1'b1;
          count_next = count + CW'(1);
        end
      end
      plid_pkg::CMD_DELETE, plid_pkg::CMD_RETRIEVE, plid_pkg::CMD_REPLACE: begin
        if (count == '0) begin
          status_next = plid_pkg::ST_EMPTY;
        end else if (pos_ext >= count_ext) begin
          status_next = plid_pkg::ST_RANGE;
        end else if (cmd.cmd == plid_pkg::CMD_DELETE) begin
          do_delete  = 1'b1;
          read_next  = cell_word[rd_idx];
          count_next = count - CW'(1);
        end else if (cmd.cmd == plid_pkg::CMD_RETRIEVE) begin
          read_next = cell_word[rd_idx];
        end else begin
          do_replace = 1'b1;
        end
      end
      plid_pkg::CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = plid_pkg::CELL_HOLD;
      if (accept) begin
        if (do_insert && CMPW'(i) > pos_ext) begin
          cell_op[i] = plid_pkg::CELL_TAKE_LEFT;
        end else if ((do_insert || do_replace) && CMPW'(i) == pos_ext) begin
          cell_op[i] = plid_pkg::CELL_LOAD;
        end else if (do_delete && CMPW'(i) >= pos_ext) begin
          cell_op[i] = plid_pkg::CELL_TAKE_RIGHT;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [plid_pkg::WORD_W-1:0] left_word;
    logic [plid_pkg::WORD_W-1:0] right_word;

    if (g == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_inner_left
      assign left_word = cell_word[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_word = cell_word[g];
    end else begin : g_inner_right
      assign right_word = cell_word[g+1];
    end

    plid_cell u_cell (
      .clk        (clk),
      .op         (cell_op[g]),
      .load_word  (cmd.value),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (cell_word[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value  <= read_next;
      rsp.status      <= status_next;
      rsp.entry_count <= plid_pkg::CNT_W'(count_next);
      rsp.is_empty    <= (count_next == '0);
      rsp.is_full     <= (count_next == CW'(DEPTH));
    end
  end

endmodule

// ===== tb/tb_positional_insert_delete_list.sv =====
// Testbench for the positional insert/delete list: directed and random command traffic.
`timescale 1ns / 1ps

module tb_positional_insert_delete_list;

  localparam int LIST_DEPTH = 16;
  localparam logic [2:0] CMD_TOP = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  plid_pkg::in_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b1;
  plid_pkg::out_t rsp;

  logic [plid_pkg::WORD_W-1:0] list_mem [LIST_DEPTH];
  int list_len = 0;
  plid_pkg::out_t pending_rsp [$];
  int err_count = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;

  positional_insert_delete_list #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[positional_insert_delete_list] ERROR");
    $finish;
  end

  function automatic plid_pkg::out_t apply_cmd(input plid_pkg::in_t w);
    plid_pkg::out_t r;
    int i;
    r = '0;
    r.status = plid_pkg::ST_OK;
    case (w.cmd)
      plid_pkg::CMD_INSERT: begin
        if (w.position > list_len) begin
          r.status = plid_pkg::ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = plid_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > w.position; i--) list_mem[i] = list_mem[i-1];
          list_mem[w.position] = w.value;
          list_len++;
        end
      end
      plid_pkg::CMD_DELETE, plid_pkg::CMD_RETRIEVE, plid_pkg::CMD_REPLACE: begin
        if (list_len == 0) begin
          r.status = plid_pkg::ST_EMPTY;
        end else if (w.position >= list_len) begin
          r.status = plid_pkg::ST_RANGE;
        end else if (w.cmd == plid_pkg::CMD_DELETE) begin
          r.read_value = list_mem[w.position];
          for (i = w.position; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end else if (w.cmd == plid_pkg::CMD_RETRIEVE) begin
          r.read_value = list_mem[w.position];
        end else begin
          list_mem[w.position] = w.value;
        end
      end
      plid_pkg::CMD_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = plid_pkg::CNT_W'(list_len);
    r.is_empty = (list_len == 0);
    r.is_full = (list_len >= LIST_DEPTH);
    return r;
  endfunction

  function automatic plid_pkg::in_t make_word(input logic [2:0] op, input int pos,
                                              input logic [plid_pkg::WORD_W-1:0] val);
    plid_pkg::in_t w;
    w.cmd = op;
    w.position = plid_pkg::POS_W'(pos);
    w.value = val;
    return w;
  endfunction

  function automatic plid_pkg::in_t pick_word(input int insert_pct);
    plid_pkg::in_t w;
    int roll;
    w.value = $urandom();
    roll = $urandom_range(99);
    if (roll < insert_pct) begin
      w.cmd = plid_pkg::CMD_INSERT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 40) w.cmd = plid_pkg::CMD_DELETE;
      else if (roll < 65) w.cmd = plid_pkg::CMD_RETRIEVE;
      else if (roll < 90) w.cmd = plid_pkg::CMD_REPLACE;
      else if (roll < 95) w.cmd = plid_pkg::CMD_CLEAR;
      else w.cmd = 3'($urandom_range(CMD_TOP, plid_pkg::CMD_CLEAR + 1));
    end
    if ($urandom_range(9) == 0) begin
      w.position = plid_pkg::POS_W'($urandom_range((1 << plid_pkg::POS_W) - 1));
    end else if (w.cmd == plid_pkg::CMD_INSERT) begin
      w.position = plid_pkg::POS_W'($urandom_range(list_len, 0));
    end else if (list_len == 0) begin
      w.position = '0;
    end else begin
      w.position = plid_pkg::POS_W'($urandom_range(list_len - 1, 0));
    end
    return w;
  endfunction

  // Call at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input plid_pkg::in_t w);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    do @(negedge clk); while (!cmd_ready);
    @(posedge clk);
    pending_rsp.push_back(apply_cmd(w));
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic check_result(input plid_pkg::out_t got);
    plid_pkg::out_t want;
    if (pending_rsp.size() == 0) begin
      $error("unexpected result word %p", got);
      err_count++;
      return;
    end
    want = pending_rsp.pop_front();
    if (got.read_value !== want.read_value) begin
      $error("read_value expected %h got %h", want.read_value, got.read_value);
      err_count++;
    end
    if (got.status !== want.status) begin
      $error("status expected %0d got %0d", want.status, got.status);
      err_count++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count expected %0d got %0d", want.entry_count, got.entry_count);
      err_count++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty expected %b got %b", want.is_empty, got.is_empty);
      err_count++;
    end
    if (got.is_full !== want.is_full) begin
      $error("is_full expected %b got %b", want.is_full, got.is_full);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Sample at the falling edge: the handshake then completes at the next rising edge.
  always @(negedge clk) begin
    if (!rst && rsp_valid && rsp_ready) check_result(rsp);
  end

  task automatic test_empty_list();
    send_word(make_word(plid_pkg::CMD_DELETE, 0, '0));
    send_word(make_word(plid_pkg::CMD_RETRIEVE, 0, '0));
    send_word(make_word(plid_pkg::CMD_REPLACE, 0, '1));
    send_word(make_word(plid_pkg::CMD_INSERT, 1, '1));
    send_word(make_word(plid_pkg::CMD_CLEAR, 0, '0));
    send_word(make_word(3'(plid_pkg::CMD_CLEAR + 1), 0, '0));
    send_word(make_word(CMD_TOP, (1 << plid_pkg::POS_W) - 1, '1));
  endtask

  task automatic test_full_list();
    int i;
    for (i = 0; i < LIST_DEPTH; i++) begin
      send_word(make_word(plid_pkg::CMD_INSERT, (i % 3 == 2) ? 0 : i,
                          (i % 3 == 0) ? '0 : (i % 3 == 1) ? '1 : $urandom()));
    end
    send_word(make_word(plid_pkg::CMD_INSERT, LIST_DEPTH, $urandom()));
    send_word(make_word(plid_pkg::CMD_INSERT, (1 << plid_pkg::POS_W) - 1, $urandom()));
    send_word(make_word(plid_pkg::CMD_DELETE, LIST_DEPTH, '0));
    send_word(make_word(plid_pkg::CMD_DELETE, LIST_DEPTH - 1, '0));
  endtask

  task automatic test_random_traffic(input int n, input int gap_pct, input int stall,
                                     input int insert_pct);
    int i;
    send_gap_pct = gap_pct;
    stall_pct = stall;
    for (i = 0; i < n; i++) send_word(pick_word(insert_pct));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_full_list();
    test_random_traffic(170, 0, 0, 45);
    wait_drained();
    test_random_traffic(170, 55, 0, 55);
    test_random_traffic(170, 0, 55, 40);
    wait_drained();
    test_random_traffic(170, 7, 7, 50);
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("[positional_insert_delete_list] OK");
    end else begin
      $display("[positional_insert_delete_list] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/plid_pkg.sv
rtl/core/plid_cell.sv
rtl/core/positional_insert_delete_list.sv
tb/tb_positional_insert_delete_list.sv
